// ===== rtl/core/gbio_pkg.sv =====
package gbio_pkg;

  // clamp limits for the glyph geometry
  localparam logic [6:0] MaxGlyphHeight = 7'd64;
  localparam logic [5:0] MaxGlyphWidth  = 6'd32;

  // entries in the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // configuration register indexes
  localparam logic [2:0] RegGlyphHeight = 3'd0;
  localparam logic [2:0] RegEmbolden    = 3'd1;
  localparam logic [2:0] RegSlant       = 3'd2;
  localparam logic [2:0] RegOutlineMode = 3'd3;

  // one styled row as handed from front to back
  typedef struct packed {
    logic [63:0] row;      // styled row of this request
    logic [63:0] up;       // styled row two above, blank near the top
    logic [63:0] mid;      // styled row just above, blank on the first row
    logic [5:0]  width;    // final width of the result rows
    logic        last;     // last row of the glyph
    logic        outline;  // outline ring requested
  } row_entry_t;

  // ring pixels of one framed row from three unframed glyph rows
  function automatic logic [63:0] ring_row(input logic [63:0] up,
                                           input logic [63:0] mid,
                                           input logic [63:0] down);
    logic [63:0] fu;
    logic [63:0] fm;
    logic [63:0] fd;
    fu = up >> 1;
    fm = mid >> 1;
    fd = down >> 1;
    return ((fm << 1) | (fm >> 1) | fu | fd) & ~fm;
  endfunction

endpackage

// ===== rtl/core/glyph_bold_italic_outline.sv =====
// Styles 1-bpp glyph rows with synthetic bold, italic and a one-pixel outline
// ring, in that order. Push one source row per cycle with the glyph's width;
// results come out of a queue-like port in order. Without outline each row
// gives one result and the block sustains one row per cycle while results are
// popped, each row passing through the queue and the output register before its
// result shows. With outline each row gives one result lagging by one row, and
// the glyph's last row gives three, so it stays at the head of the queue until the
// output register has taken all three; the two-entry queue between the classifying
// front and the result back takes the next row meanwhile, and full then goes high
// once per glyph. Configuration writes take effect from the next row and are meant
// for idle periods; glyph_height is the row count of every glyph and the row
// counter restarts after each glyph's last row.
module glyph_bold_italic_outline import gbio_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [31:0] row_pixels_i,
  input  logic [5:0]  glyph_width_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_pixels_o,
  output logic [5:0]  out_width_o,
  output logic        run_last_o,
  output logic        glyph_last_o
);

  row_entry_t front_entry;
  row_entry_t head_entry;
  logic       accept;
  logic       q_empty;
  logic       head_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // front: classify and style each request
  gbio_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .row_pixels_i  (row_pixels_i),
    .glyph_width_i (glyph_width_i),
    .entry_o       (front_entry)
  );

  // decoupling queue
  gbio_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (front_entry),
    .rd_i    (head_pop),
    .rdata_o (head_entry),
    .full_o  (full),
    .empty_o (q_empty)
  );

  // back: result rows and outline flush
  gbio_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_entry),
    .head_valid_i (!q_empty),
    .head_pop_o   (head_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_pixels_o (out_pixels_o),
    .out_width_o  (out_width_o),
    .run_last_o   (run_last_o),
    .glyph_last_o (glyph_last_o)
  );

endmodule

// ===== rtl/core/gbio_front.sv =====
module gbio_front import gbio_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [6:0]       cfg_data_i,
  input  logic             accept_i,
  input  logic [31:0]      row_pixels_i,
  input  logic [5:0]       glyph_width_i,
  output row_entry_t       entry_o
);

  logic [6:0]  glyph_height_q;
  logic        embolden_q;
  logic        slant_q;
  logic        outline_mode_q;
  logic [6:0]  row_index_q;
  logic [63:0] prev_row_q;
  logic [63:0] prev2_row_q;

  logic [6:0]  height;
  logic [5:0]  width_in;
  logic        last;
  logic [6:0]  y;
  logic [6:0]  rows_left;
  logic [4:0]  shear;
  logic [63:0] mask;
  logic [63:0] row_src;
  logic [63:0] row_bold;
  logic [63:0] row_styled;
  logic [6:0]  width_sum;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_height_q <= 7'd16;
      embolden_q     <= 1'b0;
      slant_q        <= 1'b0;
      outline_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegGlyphHeight: glyph_height_q <= cfg_data_i;
        RegEmbolden:    embolden_q     <= cfg_data_i[0];
        RegSlant:       slant_q        <= cfg_data_i[0];
        RegOutlineMode: outline_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp height and width into range
  always_comb begin
    height = glyph_height_q;
    if (height == 7'd0) begin
      height = 7'd1;
    end else if (height > MaxGlyphHeight) begin
      height = MaxGlyphHeight;
    end
    width_in = glyph_width_i;
    if (width_in == 6'd0) begin
      width_in = 6'd1;
    end else if (width_in > MaxGlyphWidth) begin
      width_in = MaxGlyphWidth;
    end
  end

  // row position, rows past the height fold onto the last row
  assign last      = (row_index_q >= height - 7'd1);
  assign y         = last ? (height - 7'd1) : row_index_q;
  assign rows_left = height - y;
  assign shear     = rows_left[6:2];

  // bold smear then italic shear
  assign mask       = ~(64'hFFFF_FFFF_FFFF_FFFF >> width_in);
  assign row_src    = {row_pixels_i, 32'h0} & mask;
  assign row_bold   = embolden_q ? (row_src | (row_src >> 1)) : row_src;
  assign row_styled = slant_q ? (row_bold >> shear) : row_bold;

  // final width, framed by one pixel on each side for the outline
  assign width_sum = {1'b0, width_in}
                   + {6'd0, embolden_q}
                   + (slant_q ? {2'd0, height[6:2]} : 7'd0)
                   + (outline_mode_q ? 7'd2 : 7'd0);

  // request handed to the queue
  always_comb begin
    entry_o.row     = row_styled;
    entry_o.up      = (y >= 7'd2) ? prev2_row_q : 64'd0;
    entry_o.mid     = (y >= 7'd1) ? prev_row_q : 64'd0;
    entry_o.width   = width_sum[5:0];
    entry_o.last    = last;
    entry_o.outline = outline_mode_q;
  end

  // neighbour rows and row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_index_q <= 7'd0;
      prev_row_q  <= 64'd0;
      prev2_row_q <= 64'd0;
    end else if (accept_i) begin
      row_index_q <= last ? 7'd0 : row_index_q + 7'd1;
      prev_row_q  <= row_styled;
      prev2_row_q <= prev_row_q;
    end
  end

endmodule

// ===== rtl/core/gbio_queue.sv =====
module gbio_queue import gbio_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  row_entry_t wdata_i,
  input  logic       rd_i,
  output row_entry_t rdata_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);

  row_entry_t            slot_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q;
  logic [PtrW-1:0]       rd_ptr_q;
  logic [CntW-1:0]       count_q;
  logic                  do_wr;
  logic                  do_rd;

  assign full_o  = (count_q == DepthCnt);
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/gbio_back.sv =====
module gbio_back import gbio_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  row_entry_t  head_i,
  input  logic        head_valid_i,
  output logic        head_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [63:0] out_pixels_o,
  output logic [5:0]  out_width_o,
  output logic        run_last_o,
  output logic        glyph_last_o
);

  localparam logic [1:0] PhFirst = 2'd0;
  localparam logic [1:0] PhMid   = 2'd1;
  localparam logic [1:0] PhLast  = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic        out_valid_q;
  logic [63:0] pix_q;
  logic [5:0]  width_q;
  logic        run_last_q;
  logic        glyph_last_q;

  logic        load;
  logic        final_phase;
  logic [63:0] pix_d;
  logic        run_last_d;
  logic        glyph_last_d;

  // next result from the head request
  assign load        = head_valid_i && (!out_valid_q || pop_i);
  assign final_phase = !head_i.outline || !head_i.last || (phase_q == PhLast);
  assign head_pop_o  = load && final_phase;

  always_comb begin
    pix_d        = head_i.row;
    run_last_d   = 1'b1;
    glyph_last_d = head_i.last;
    if (head_i.outline) begin
      unique case (phase_q)
        PhFirst: begin
          pix_d        = ring_row(head_i.up, head_i.mid, head_i.row);
          run_last_d   = !head_i.last;
          glyph_last_d = 1'b0;
        end
        PhMid: begin
          pix_d        = ring_row(head_i.mid, head_i.row, 64'd0);
          run_last_d   = 1'b0;
          glyph_last_d = 1'b0;
        end
        PhLast: begin
          pix_d        = ring_row(head_i.row, 64'd0, 64'd0);
          run_last_d   = 1'b1;
          glyph_last_d = 1'b1;
        end
        default: begin
          pix_d        = head_i.row;
          run_last_d   = 1'b1;
          glyph_last_d = head_i.last;
        end
      endcase
    end
  end

  // flush sequencer for the outline tail rows
  always_comb begin
    phase_d = phase_q;
    if (load) begin
      unique case (phase_q)
        PhFirst: phase_d = final_phase ? PhFirst : PhMid;
        PhMid:   phase_d = PhLast;
        PhLast:  phase_d = PhFirst;
        default: phase_d = PhFirst;
      endcase
    end
  end

  // control state of the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhFirst;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q        <= pix_d;
      width_q      <= head_i.width;
      run_last_q   <= run_last_d;
      glyph_last_q <= glyph_last_d;
    end
  end

  assign empty_o      = !out_valid_q;
  assign out_pixels_o = pix_q;
  assign out_width_o  = width_q;
  assign run_last_o   = run_last_q;
  assign glyph_last_o = glyph_last_q;

endmodule

// ===== rtl/core/gbio_checker.sv =====
module gbio_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [63:0] out_pixels_o,
  input logic [5:0]  out_width_o,
  input logic        run_last_o,
  input logic        glyph_last_o
);

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_pixels_o)))
    else $error("result changed while waiting");

  // the glyph's final row also closes its request
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && glyph_last_o) |-> run_last_o)
    else $error("glyph_last without run_last");

  // a result row is never zero wide
  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_width_o != 6'd0))
    else $error("zero result width");

  // a result shows once an accepted request has had time to pass the queue and output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |-> ##2 !empty)
    else $error("accepted row produced no result");

  // the queue only backs up behind a waiting result
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("queue full with output register empty");

endmodule

bind glyph_bold_italic_outline gbio_checker u_gbio_checker (.*);

// ===== sim/gbio_tb_pkg.sv =====
package gbio_tb_pkg;
  import gbio_pkg::*;

  // one styled row as it should appear on the result ports
  typedef struct packed {
    logic [63:0] pixels;
    logic [5:0]  width;
    logic        run_last;
    logic        glyph_last;
  } styled_row_t;

  class style_scoreboard;
    // style registers as last written
    logic [6:0]  height;
    logic        bold;
    logic        italic;
    logic        outline;

    // glyph progress and the two styled rows above the current one
    logic [6:0]  row_idx;
    logic [63:0] row_above;
    logic [63:0] row_two_above;

    styled_row_t rows_due[$];

    int n_errors;
    int n_rows_in;
    int n_rows_out;
    int n_ring_rows;

    function new();
      height        = 7'd16;
      bold          = 1'b0;
      italic        = 1'b0;
      outline       = 1'b0;
      row_idx       = '0;
      row_above     = '0;
      row_two_above = '0;
      n_errors      = 0;
      n_rows_in     = 0;
      n_rows_out    = 0;
      n_ring_rows   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [6:0] val);
      case (idx)
        RegGlyphHeight: height  = val;
        RegEmbolden:    bold    = val[0];
        RegSlant:       italic  = val[0];
        RegOutlineMode: outline = val[0];
        default: ;
      endcase
    endfunction

    // glyph height after clamping to 1..MaxGlyphHeight
    function int eff_height();
      int h;
      h = height;
      if (h < 1) h = 1;
      if (h > MaxGlyphHeight) h = MaxGlyphHeight;
      return h;
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    // ring of one framed row: pad column on the left, 4-neighbour growth minus the body
    function logic [63:0] halo(logic [63:0] above, logic [63:0] here, logic [63:0] below);
      logic [63:0] body;
      logic [63:0] grown;
      body  = {1'b0, here[63:1]};
      grown = {body[62:0], 1'b0} | {1'b0, body[63:1]}
            | {1'b0, above[63:1]} | {1'b0, below[63:1]};
      return grown & ~body;
    endfunction

    // style one accepted source row and queue the rows it should produce
    function void note_row(logic [31:0] px, logic [5:0] w_in);
      styled_row_t e;
      int h;
      int w;
      int y;
      int wd;
      bit at_end;
      logic [63:0] row;
      logic [63:0] above;
      logic [63:0] two_above;

      h = eff_height();
      w = w_in;
      if (w < 1) w = 1;
      if (w > MaxGlyphWidth) w = MaxGlyphWidth;
      at_end = (row_idx >= h - 1);
      y = at_end ? h - 1 : int'(row_idx);

      // keep only the first w columns
      row = {px, 32'h0} & ~(64'hFFFF_FFFF_FFFF_FFFF >> w);
      wd  = w;
      if (bold) begin
        row = row | (row >> 1);
        wd++;
      end
      if (italic) begin
        row = row >> ((h - y) >> 2);
        wd += h >> 2;
      end

      if (outline) begin
        two_above    = (y >= 2) ? row_two_above : 64'h0;
        above        = (y >= 1) ? row_above : 64'h0;
        e.width      = 6'(wd + 2);
        e.pixels     = halo(two_above, above, row);
        e.run_last   = !at_end;
        e.glyph_last = 1'b0;
        rows_due.push_back(e);
        // last glyph row flushes the two rows below it
        if (at_end) begin
          e.pixels = halo(above, row, 64'h0);
          rows_due.push_back(e);
          e.pixels     = halo(row, 64'h0, 64'h0);
          e.run_last   = 1'b1;
          e.glyph_last = 1'b1;
          rows_due.push_back(e);
        end
        n_ring_rows++;
      end else begin
        e.pixels     = row;
        e.width      = 6'(wd);
        e.run_last   = 1'b1;
        e.glyph_last = at_end;
        rows_due.push_back(e);
      end

      row_two_above = row_above;
      row_above     = row;
      row_idx       = at_end ? 7'd0 : row_idx + 7'd1;
      n_rows_in++;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      n_errors++;
      $display("[%0t] result %0d: %s got %h expected %h", $time, n_rows_out, what, got, want);
    endtask

    // compare one popped row with the oldest one due
    task check(logic [63:0] pix, logic [5:0] wd, logic rl, logic gl);
      styled_row_t want;
      n_rows_out++;
      if (rows_due.size() == 0) begin
        report("row with none due, pixels", pix, 64'h0);
      end else begin
        want = rows_due.pop_front();
        if (pix !== want.pixels) report("out_pixels", pix, want.pixels);
        if (wd !== want.width) report("out_width", 64'(wd), 64'(want.width));
        if (rl !== want.run_last) report("run_last", 64'(rl), 64'(want.run_last));
        if (gl !== want.glyph_last) report("glyph_last", 64'(gl), 64'(want.glyph_last));
      end
    endtask
  endclass

endpackage

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gbio_pkg::*;
  import gbio_tb_pkg::*;

  localparam int CycleLimit = 200_000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [6:0]  cfg_data_i;
  logic        push;
  logic        full;
  logic [31:0] row_pixels_i;
  logic [5:0]  glyph_width_i;
  logic        empty;
  logic        pop;
  logic [63:0] out_pixels_o;
  logic [5:0]  out_width_o;
  logic        run_last_o;
  logic        glyph_last_o;

  style_scoreboard sb;

  // longest wait each side may draw before its next request
  int in_gap_max;
  int out_gap_max;
  int n_styles;

  glyph_bold_italic_outline uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .row_pixels_i  (row_pixels_i),
    .glyph_width_i (glyph_width_i),
    .empty         (empty),
    .pop           (pop),
    .out_pixels_o  (out_pixels_o),
    .out_width_o   (out_width_o),
    .run_last_o    (run_last_o),
    .glyph_last_o  (glyph_last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run-length guard
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timed out after %0d cycles", cycles);
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls, check every popped row
  initial begin : result_sink
    int gap;
    pop <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      sb.check(out_pixels_o, out_width_o, run_last_o, glyph_last_o);
    end
  end

  // one register write; valid stays high for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // drain the block, then write all four style registers
  task automatic set_style(input logic [6:0] h, input bit b, input bit it, input bit o);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    write_reg(RegGlyphHeight, h);
    write_reg(RegEmbolden, 7'(b));
    write_reg(RegSlant, 7'(it));
    write_reg(RegOutlineMode, 7'(o));
    cfg_valid_i <= 1'b0;
    n_styles++;
  endtask

  // push one source row; push stays high when the next request follows at once
  task automatic send_row(input logic [31:0] px, input logic [5:0] w);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    row_pixels_i  <= px;
    glyph_width_i <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_row(px, w);
  endtask

  initial begin : stimulus
    logic [6:0]  hgt;
    logic [31:0] px;
    logic [5:0]  w;
    int heff;
    int rem;
    int n;
    int random_rows;

    sb            = new();
    n_styles      = 0;
    random_rows   = 0;
    in_gap_max    = 0;
    out_gap_max   = 0;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= RegGlyphHeight;
    cfg_data_i    <= '0;
    push          <= 1'b0;
    row_pixels_i  <= '0;
    glyph_width_i <= 6'd1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain rows: full width, zero and oversized widths, pixels past the width
    set_style(7'd4, 1'b0, 1'b0, 1'b0);
    send_row(32'hFFFF_FFFF, 6'd32);
    send_row(32'hFFFF_FFFF, 6'd0);
    send_row(32'hFFFF_FFFF, 6'd63);
    send_row(32'hAAAA_AAAA, 6'd5);

    // every style at once over a whole short glyph
    in_gap_max  = 8;
    out_gap_max = 8;
    set_style(7'd4, 1'b1, 1'b1, 1'b1);
    send_row(32'hFFFF_FFFF, 6'd32);
    send_row(32'h8000_0001, 6'd32);
    send_row(32'h5555_5555, 6'd17);
    send_row(32'hFFFF_FFFF, 6'd32);

    // tallest glyph, then an oversized height mid-glyph for the widest result
    set_style(MaxGlyphHeight, 1'b1, 1'b1, 1'b0);
    send_row(32'hFFFF_FFFF, 6'd32);
    send_row(32'hC000_0003, 6'd31);
    set_style(7'd127, 1'b1, 1'b1, 1'b1);
    send_row(32'hFFFF_FFFF, 6'd32);

    // zero height: row counter past the end, every row closes a glyph
    set_style(7'd0, 1'b1, 1'b0, 1'b1);
    send_row(32'h8000_0000, 6'd1);
    send_row(32'hFFFF_FFFF, 6'd32);
    set_style(7'd1, 1'b0, 1'b1, 1'b0);
    send_row(32'h1234_5678, 6'd24);

    // height shrunk mid-glyph with outline on
    set_style(7'd8, 1'b0, 1'b1, 1'b1);
    send_row(32'hF0F0_F0F0, 6'd32);
    send_row(32'h0F0F_0F0F, 6'd32);
    send_row(32'hFFFF_0000, 6'd16);
    set_style(7'd2, 1'b1, 1'b0, 1'b1);
    send_row(32'h00FF_00FF, 6'd32);
    set_style(7'd2, 1'b0, 1'b0, 1'b1);
    send_row(32'hFFFF_FFFF, 6'd2);
    send_row(32'hFFFF_FFFF, 6'd2);

    // random styles, mostly whole glyphs, some cut short
    while (random_rows < 200) begin
      case ($urandom_range(0, 24))
        0:       hgt = 7'd0;
        1:       hgt = 7'($urandom_range(65, 127));
        2:       hgt = MaxGlyphHeight;
        default: hgt = 7'($urandom_range(1, 8));
      endcase
      set_style(hgt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 8;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;

      heff = sb.eff_height();
      rem  = (sb.row_idx >= heff - 1) ? 1 : heff - int'(sb.row_idx);
      if ($urandom_range(0, 3) != 0) n = rem + heff * $urandom_range(0, 1);
      else n = $urandom_range(1, heff);
      if (n > 200 - random_rows) n = 200 - random_rows;

      repeat (n) begin
        case ($urandom_range(0, 7))
          0:       px = 32'hFFFF_FFFF;
          1:       px = 32'h1 << $urandom_range(0, 31);
          2:       px = 32'h0;
          default: px = $urandom;
        endcase
        case ($urandom_range(0, 9))
          0:       w = 6'd0;
          1:       w = 6'($urandom_range(33, 63));
          default: w = 6'($urandom_range(1, 32));
        endcase
        send_row(px, w);
        random_rows++;
      end
    end

    // drain and give the block time to show any stray row
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("%0d source rows over %0d style settings, %0d styled rows checked",
             sb.n_rows_in, n_styles, sb.n_rows_out);
    $display("%0d rows went through the outline path, %0d mismatches",
             sb.n_ring_rows, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
